### design/ieu_pkg.sv
// Package for the instruction execute unit: sizes, codes and shared types.
`default_nettype none

package ieu_pkg;

   // Storage sizes
   localparam int NUM_REGS    = 32;
   localparam int DATA_DEPTH  = 1024;
   localparam int LABEL_DEPTH = 64;
   localparam int INST_DEPTH  = 1024;

   localparam int RF_AW  = $clog2(NUM_REGS);
   localparam int DM_AW  = $clog2(DATA_DEPTH);
   localparam int LT_AW  = $clog2(LABEL_DEPTH);
   localparam int PC_W   = $clog2(INST_DEPTH);
   localparam int DATA_W = 32;

   // Item field widths
   localparam int FUNC_W  = 4;
   localparam int REG_W   = 5;
   localparam int OPND_W  = 17;
   localparam int MADDR_W = 10;
   localparam int LIDX_W  = 6;
   localparam int PCOUT_W = 10;

   // Operand codes from this value up are immediates
   localparam logic [OPND_W-1:0] IMM_BASE = OPND_W'(NUM_REGS);

   // Function codes
   localparam logic [FUNC_W-1:0] FN_ADD       = 4'd0;
   localparam logic [FUNC_W-1:0] FN_SUB       = 4'd1;
   localparam logic [FUNC_W-1:0] FN_AND       = 4'd2;
   localparam logic [FUNC_W-1:0] FN_OR        = 4'd3;
   localparam logic [FUNC_W-1:0] FN_SLT       = 4'd4;
   localparam logic [FUNC_W-1:0] FN_LI        = 4'd5;
   localparam logic [FUNC_W-1:0] FN_MOVE      = 4'd6;
   localparam logic [FUNC_W-1:0] FN_LW        = 4'd7;
   localparam logic [FUNC_W-1:0] FN_SW        = 4'd8;
   localparam logic [FUNC_W-1:0] FN_J         = 4'd9;
   localparam logic [FUNC_W-1:0] FN_BEQ       = 4'd10;
   localparam logic [FUNC_W-1:0] FN_SYSCALL   = 4'd11;
   localparam logic [FUNC_W-1:0] FN_SET_LABEL = 4'd12;

   // Syscall codes held in v0, and the registers involved
   localparam logic [DATA_W-1:0] SYS_PRINT_INT = 32'd1;
   localparam logic [DATA_W-1:0] SYS_READ_INT  = 32'd5;
   localparam logic [DATA_W-1:0] SYS_EXIT      = 32'd10;
   localparam logic [RF_AW-1:0]  REG_V0        = RF_AW'(2);
   localparam logic [RF_AW-1:0]  REG_A0        = RF_AW'(4);

   // One decoded instruction
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [REG_W-1:0]   dest_reg;
      logic [OPND_W-1:0]  operand_a;
      logic [OPND_W-1:0]  operand_b;
      logic [DATA_W-1:0]  value;
      logic [MADDR_W-1:0] mem_addr;
      logic [LIDX_W-1:0]  label_index;
   } item_type;

   typedef struct packed {
      logic              en;
      logic [RF_AW-1:0]  addr;
      logic [DATA_W-1:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic              en;
      logic [DM_AW-1:0]  addr;
      logic [DATA_W-1:0] data;
   } dm_wr_type;

   typedef struct packed {
      logic             en;
      logic [LT_AW-1:0] addr;
      logic [PC_W-1:0]  data;
   } lt_wr_type;

   // Everything one executed item produces
   typedef struct packed {
      logic [PC_W-1:0]   pc;
      logic              halt;
      logic              print_valid;
      logic [DATA_W-1:0] print_value;
      rf_wr_type         rf_wr;
      dm_wr_type         dm_wr;
      lt_wr_type         lt_wr;
   } exec_type;

endpackage

`default_nettype wire

### design/ieu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ieu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ieu_regfile.sv
// Register file: three read ports over copied RAMs, valid bits, write bypass, v0/a0 shadows.
`default_nettype none

module ieu_regfile (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [ieu_pkg::RF_AW-1:0] rd_a_addr,
   input  wire logic [ieu_pkg::RF_AW-1:0] rd_b_addr,
   input  wire logic [ieu_pkg::RF_AW-1:0] rd_s_addr,
   input  wire ieu_pkg::rf_wr_type       wr,
   output logic [ieu_pkg::DATA_W-1:0]    a_data,
   output logic [ieu_pkg::DATA_W-1:0]    b_data,
   output logic [ieu_pkg::DATA_W-1:0]    s_data,
   output logic [ieu_pkg::DATA_W-1:0]    v0_data,
   output logic [ieu_pkg::DATA_W-1:0]    a0_data
);

   localparam int NPORTS = 3;

   logic [ieu_pkg::RF_AW-1:0]    rd_addr [NPORTS];
   logic [ieu_pkg::DATA_W-1:0]   rd_data [NPORTS];
   logic [ieu_pkg::NUM_REGS-1:0] vld_ff, vld_in;
   logic [ieu_pkg::DATA_W-1:0]   v0_ff, v0_in, a0_ff, a0_in;

   assign rd_addr[0] = rd_a_addr;
   assign rd_addr[1] = rd_b_addr;
   assign rd_addr[2] = rd_s_addr;

   // Written flags: an entry never written reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   // Shadows of v0 and a0 for the syscall
   assign v0_in = (wr.en && wr.addr == ieu_pkg::REG_V0) ? wr.data : v0_ff;
   assign a0_in = (wr.en && wr.addr == ieu_pkg::REG_A0) ? wr.data : a0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         v0_ff  <= '0;
         a0_ff  <= '0;
      end else begin
         vld_ff <= vld_in;
         v0_ff  <= v0_in;
         a0_ff  <= a0_in;
      end
   end

   // One RAM copy per read port; same-cycle write is forwarded
   for (genvar p = 0; p < NPORTS; p++) begin : g_port
      logic [ieu_pkg::DATA_W-1:0] ram_q;
      logic                       hit_ff, vld_rd_ff;
      logic [ieu_pkg::DATA_W-1:0] byp_ff;

      ieu_ram #(
         .WIDTH(ieu_pkg::DATA_W),
         .DEPTH(ieu_pkg::NUM_REGS)
      ) u_ram (
         .clock  (clock),
         .wr_en  (wr.en),
         .wr_addr(wr.addr),
         .wr_data(wr.data),
         .rd_en  (rd_en),
         .rd_addr(rd_addr[p]),
         .rd_data(ram_q)
      );

      always_ff @(posedge clock) begin
         if (rd_en) begin
            hit_ff    <= wr.en && (wr.addr == rd_addr[p]);
            byp_ff    <= wr.data;
            vld_rd_ff <= vld_ff[rd_addr[p]];
         end
      end

      assign rd_data[p] = hit_ff ? byp_ff : (vld_rd_ff ? ram_q : '0);
   end

   assign a_data  = rd_data[0];
   assign b_data  = rd_data[1];
   assign s_data  = rd_data[2];
   assign v0_data = v0_ff;
   assign a0_data = a0_ff;

endmodule

`default_nettype wire

### design/ieu_datamem.sv
// Data memory with a clearing sweep after reset and store-to-load bypass.
`default_nettype none

module ieu_datamem (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [ieu_pkg::DM_AW-1:0] rd_addr,
   input  wire ieu_pkg::dm_wr_type        wr,
   output logic [ieu_pkg::DATA_W-1:0]     rd_data,
   output logic                           clearing
);

   logic                      clr_ff, clr_in;
   logic [ieu_pkg::DM_AW-1:0] cnt_ff, cnt_in;
   logic                      ram_we;
   logic [ieu_pkg::DM_AW-1:0] ram_wa;
   logic [ieu_pkg::DATA_W-1:0] ram_wd, ram_q, byp_ff;
   logic                      hit_ff;

   // Clearing sweep: one word per cycle from address zero up
   assign cnt_in = clr_ff ? cnt_ff + 1'b1 : cnt_ff;
   assign clr_in = clr_ff && (cnt_ff != ieu_pkg::DM_AW'(ieu_pkg::DATA_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
      end
   end

   assign ram_we = clr_ff || wr.en;
   assign ram_wa = clr_ff ? cnt_ff : wr.addr;
   assign ram_wd = clr_ff ? '0 : wr.data;

   ieu_ram #(
      .WIDTH(ieu_pkg::DATA_W),
      .DEPTH(ieu_pkg::DATA_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // Forward a store that lands in the same cycle as the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff <= wr.en && (wr.addr == rd_addr);
         byp_ff <= wr.data;
      end
   end

   assign rd_data  = hit_ff ? byp_ff : ram_q;
   assign clearing = clr_ff;

endmodule

`default_nettype wire

### design/ieu_labels.sv
// Label table: RAM with per-entry valid bits and write bypass.
`default_nettype none

module ieu_labels (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [ieu_pkg::LT_AW-1:0] rd_addr,
   input  wire ieu_pkg::lt_wr_type        wr,
   output logic [ieu_pkg::PC_W-1:0]       rd_data
);

   logic [ieu_pkg::LABEL_DEPTH-1:0] vld_ff, vld_in;
   logic [ieu_pkg::PC_W-1:0]        ram_q, byp_ff;
   logic                            hit_ff, vld_rd_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   ieu_ram #(
      .WIDTH(ieu_pkg::PC_W),
      .DEPTH(ieu_pkg::LABEL_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr.en),
      .wr_addr(wr.addr),
      .wr_data(wr.data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff    <= wr.en && (wr.addr == rd_addr);
         byp_ff    <= wr.data;
         vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? byp_ff : (vld_rd_ff ? ram_q : '0);

endmodule

`default_nettype wire

### design/ieu_exec.sv
// Execute logic: ALU, branch resolution, syscall and the writes for one item.
`default_nettype none

module ieu_exec (
   input  wire ieu_pkg::item_type          item,
   input  wire logic [ieu_pkg::DATA_W-1:0] a_reg,
   input  wire logic [ieu_pkg::DATA_W-1:0] b_reg,
   input  wire logic [ieu_pkg::DATA_W-1:0] s_reg,
   input  wire logic [ieu_pkg::DATA_W-1:0] v0_reg,
   input  wire logic [ieu_pkg::DATA_W-1:0] a0_reg,
   input  wire logic [ieu_pkg::DATA_W-1:0] mem_q,
   input  wire logic [ieu_pkg::PC_W-1:0]   label_q,
   input  wire logic [ieu_pkg::PC_W-1:0]   pc,
   input  wire logic                       halt,
   output ieu_pkg::exec_type               res
);

   logic [ieu_pkg::OPND_W-1:0] imm_a, imm_b;
   logic [ieu_pkg::DATA_W-1:0] op_a, op_b, alu;
   logic [ieu_pkg::PC_W-1:0]   pc_inc;

   // Operand select: register below the immediate base, else code minus base
   assign imm_a = item.operand_a - ieu_pkg::IMM_BASE;
   assign imm_b = item.operand_b - ieu_pkg::IMM_BASE;
   assign op_a  = (item.operand_a < ieu_pkg::IMM_BASE) ? a_reg
                                                       : ieu_pkg::DATA_W'(imm_a);
   assign op_b  = (item.operand_b < ieu_pkg::IMM_BASE) ? b_reg
                                                       : ieu_pkg::DATA_W'(imm_b);
   assign pc_inc = pc + 1'b1;

   // ALU
   always_comb begin
      case (item.func)
         ieu_pkg::FN_ADD: alu = op_a + op_b;
         ieu_pkg::FN_SUB: alu = op_a - op_b;
         ieu_pkg::FN_AND: alu = op_a & op_b;
         ieu_pkg::FN_OR:  alu = op_a | op_b;
         default:         alu = ieu_pkg::DATA_W'($signed(op_a) < $signed(op_b));
      endcase
   end

   // Next state and side effects
   always_comb begin
      res             = '0;
      res.pc          = pc;
      res.halt        = halt;
      res.rf_wr.addr  = item.dest_reg[ieu_pkg::RF_AW-1:0];
      res.dm_wr.addr  = item.mem_addr[ieu_pkg::DM_AW-1:0];
      res.dm_wr.data  = s_reg;
      res.lt_wr.addr  = item.label_index[ieu_pkg::LT_AW-1:0];
      res.lt_wr.data  = item.value[ieu_pkg::PC_W-1:0];
      if (!halt) begin
         case (item.func)
            ieu_pkg::FN_ADD, ieu_pkg::FN_SUB, ieu_pkg::FN_AND,
            ieu_pkg::FN_OR, ieu_pkg::FN_SLT: begin
               res.rf_wr.en   = 1'b1;
               res.rf_wr.data = alu;
               res.pc         = pc_inc;
            end
            ieu_pkg::FN_LI: begin
               res.rf_wr.en   = 1'b1;
               res.rf_wr.data = item.value;
               res.pc         = pc_inc;
            end
            ieu_pkg::FN_MOVE: begin
               res.rf_wr.en   = 1'b1;
               res.rf_wr.data = a_reg;
               res.pc         = pc_inc;
            end
            ieu_pkg::FN_LW: begin
               res.rf_wr.en   = 1'b1;
               res.rf_wr.data = mem_q;
               res.pc         = pc_inc;
            end
            ieu_pkg::FN_SW: begin
               res.dm_wr.en = 1'b1;
               res.pc       = pc_inc;
            end
            ieu_pkg::FN_J: begin
               res.pc = label_q;
            end
            ieu_pkg::FN_BEQ: begin
               res.pc = (a_reg == b_reg) ? label_q : pc_inc;
            end
            ieu_pkg::FN_SYSCALL: begin
               if (v0_reg == ieu_pkg::SYS_PRINT_INT) begin
                  res.print_valid = 1'b1;
                  res.print_value = a0_reg;
                  res.pc          = pc_inc;
               end else if (v0_reg == ieu_pkg::SYS_READ_INT) begin
                  res.rf_wr.en   = 1'b1;
                  res.rf_wr.addr = ieu_pkg::REG_V0;
                  res.rf_wr.data = item.value;
                  res.pc         = pc_inc;
               end else if (v0_reg == ieu_pkg::SYS_EXIT) begin
                  res.halt = 1'b1;
               end else begin
                  res.pc = pc_inc;
               end
            end
            ieu_pkg::FN_SET_LABEL: begin
               res.lt_wr.en = 1'b1;
            end
            default: begin
               res.pc = pc;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/instruction_execute_unit.sv
// Items enter the input register; the result register loads when free (rsp_valid rises).
// Throughput: one item per cycle unless rsp_ready stalls; memory reads issue at accept.
// An output register lets a new item enter while a result still waits on rsp_ready.
// Reset (synchronous): clears PC, halt flag, register and label valid bits, then a
// data memory clearing sweep over all 1024 words runs with req_ready low.
// Once the exit syscall runs, items are taken but only repeat the PC with halted set.
`default_nettype none

module instruction_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_func,
   input  wire logic [4:0]  req_dest_reg,
   input  wire logic [16:0] req_operand_a,
   input  wire logic [16:0] req_operand_b,
   input  wire logic signed [31:0] req_value,
   input  wire logic [9:0]  req_mem_addr,
   input  wire logic [5:0]  req_label_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [9:0]       rsp_pc_out,
   output logic             rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic             rsp_halted
);

   ieu_pkg::item_type          item_ff;
   ieu_pkg::exec_type          res;
   logic                       exec_ff, exec_in;
   logic                       accept, exec_fire, clearing;
   logic [ieu_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic                       halt_ff, halt_in;
   logic [ieu_pkg::DATA_W-1:0] a_reg, b_reg, s_reg, v0_reg, a0_reg, mem_q;
   logic [ieu_pkg::PC_W-1:0]   label_q;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ieu_pkg::PCOUT_W-1:0] rsp_pc_ff;
   logic                       rsp_pv_ff, rsp_halt_ff;
   logic [ieu_pkg::DATA_W-1:0] rsp_pval_ff;

   // Handshake: execute stage moves on when the output register is free or drains
   assign exec_fire = exec_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing && (!exec_ff || exec_fire);
   assign accept    = req_valid && req_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.func        <= req_func;
         item_ff.dest_reg    <= req_dest_reg;
         item_ff.operand_a   <= req_operand_a;
         item_ff.operand_b   <= req_operand_b;
         item_ff.value       <= req_value;
         item_ff.mem_addr    <= req_mem_addr;
         item_ff.label_index <= req_label_index;
      end
   end

   // Storage reads are issued with the accepted item's addresses
   ieu_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_a_addr(req_operand_a[ieu_pkg::RF_AW-1:0]),
      .rd_b_addr(req_operand_b[ieu_pkg::RF_AW-1:0]),
      .rd_s_addr(req_dest_reg[ieu_pkg::RF_AW-1:0]),
      .wr       (res.rf_wr),
      .a_data   (a_reg),
      .b_data   (b_reg),
      .s_data   (s_reg),
      .v0_data  (v0_reg),
      .a0_data  (a0_reg)
   );

   ieu_datamem u_datamem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_mem_addr[ieu_pkg::DM_AW-1:0]),
      .wr      (res.dm_wr),
      .rd_data (mem_q),
      .clearing(clearing)
   );

   ieu_labels u_labels (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_addr(req_label_index[ieu_pkg::LT_AW-1:0]),
      .wr     (res.lt_wr),
      .rd_data(label_q)
   );

   // Execute; writes are gated so a stalled item leaves no trace
   ieu_pkg::exec_type res_raw;

   ieu_exec u_exec (
      .item   (item_ff),
      .a_reg  (a_reg),
      .b_reg  (b_reg),
      .s_reg  (s_reg),
      .v0_reg (v0_reg),
      .a0_reg (a0_reg),
      .mem_q  (mem_q),
      .label_q(label_q),
      .pc     (pc_ff),
      .halt   (halt_ff),
      .res    (res_raw)
   );

   always_comb begin
      res          = res_raw;
      res.rf_wr.en = res_raw.rf_wr.en && exec_fire;
      res.dm_wr.en = res_raw.dm_wr.en && exec_fire;
      res.lt_wr.en = res_raw.lt_wr.en && exec_fire;
   end

   // Architectural state and stage valid
   assign exec_in      = accept || (exec_ff && !exec_fire);
   assign pc_in        = exec_fire ? res.pc : pc_ff;
   assign halt_in      = exec_fire ? res.halt : halt_ff;
   assign rsp_valid_in = exec_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff      <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exec_ff      <= exec_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_pc_ff   <= ieu_pkg::PCOUT_W'(res.pc);
         rsp_pv_ff   <= res.print_valid;
         rsp_pval_ff <= res.print_value;
         rsp_halt_ff <= res.halt;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pc_out      = rsp_pc_ff;
   assign rsp_print_valid = rsp_pv_ff;
   assign rsp_print_value = rsp_pval_ff;
   assign rsp_halted      = rsp_halt_ff;

endmodule

`default_nettype wire

### design/ieu_checker.sv
// Port-level checks for the instruction execute unit, bound to the top level.
`default_nettype none

module ieu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [9:0]  rsp_pc_out,
   input wire logic        rsp_print_valid,
   input wire logic signed [31:0] rsp_print_value,
   input wire logic        rsp_halted
);

   logic       rsp_take;
   logic       seen_halt_ff, seen_halt_in;
   logic [9:0] halt_pc_ff, halt_pc_in;

   assign rsp_take = rsp_valid && rsp_ready;

   // Remember the PC of the first delivered halted item
   assign seen_halt_in = seen_halt_ff || (rsp_take && rsp_halted);
   assign halt_pc_in   = (rsp_take && rsp_halted && !seen_halt_ff) ? rsp_pc_out : halt_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
         halt_pc_ff   <= '0;
      end else begin
         seen_halt_ff <= seen_halt_in;
         halt_pc_ff   <= halt_pc_in;
      end
   end

   // Halt is sticky
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_halt_ff |-> rsp_halted)
      else $error("halted dropped after exit");

   // PC frozen once halted
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_halt_ff |-> rsp_pc_out == halt_pc_ff)
      else $error("PC moved after exit");

   // No print value without a print
   a_print_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_value == 32'sd0)
      else $error("print value nonzero without print");

   // A print never comes from a halted item
   a_print_not_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |-> !rsp_halted)
      else $error("print while halted");

   // Stalled result stays valid with its PC held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc_out))
      else $error("result changed while stalled");

endmodule

bind instruction_execute_unit ieu_checker u_ieu_checker (.*);

`default_nettype wire
